>>> design/wfsc_pkg.sv
// Shared types, codes, widths and the sequencer program of the waypoint follower.
`timescale 1ns / 1ps

package wfsc_pkg;

    // Item codes carried in the slave-side tuser
    typedef logic [1:0] t_op;
    localparam t_op OP_TICK   = 2'd0;
    localparam t_op OP_APPEND = 2'd1;
    localparam t_op OP_STOP   = 2'd2;

    // Result status carried in the master-side tuser
    typedef logic [2:0] t_status;
    localparam t_status ST_NONE    = 3'd0;
    localparam t_status ST_SETPT   = 3'd1;
    localparam t_status ST_REACHED = 3'd2;
    localparam t_status ST_IDLE    = 3'd3;
    localparam t_status ST_FULL    = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL  = 1'd1;
    localparam logic [CFG_W-1:0] MAX_STEP_RST = 12'd200;
    localparam logic [CFG_W-1:0] ARRIVAL_RST  = 12'd50;

    // Datapath widths
    localparam int POS_W = 16;
    localparam int MAG_W = 16;
    localparam int PRD_W = 32;
    localparam int SQ_W  = 34;
    localparam int LEN_W = 17;
    localparam int NUM_W = 29;
    localparam int DEN_W = 18;
    localparam int QUO_W = 13;
    localparam int IDX_W = 5;
    localparam logic [SQ_W-1:0] SQ_BIT0 = 34'h1_0000_0000;

    // Sequencer program
    typedef logic [4:0] t_pc;
    typedef logic [4:0] t_cnt;

    localparam t_pc PC_WAIT   = 5'd0;
    localparam t_pc PC_CHECK  = 5'd1;
    localparam t_pc PC_DIFF   = 5'd2;
    localparam t_pc PC_SQX    = 5'd3;
    localparam t_pc PC_SQY    = 5'd4;
    localparam t_pc PC_SQZ    = 5'd5;
    localparam t_pc PC_SQLOAD = 5'd6;
    localparam t_pc PC_SQIT   = 5'd7;
    localparam t_pc PC_CMP    = 5'd8;
    localparam t_pc PC_MULX   = 5'd9;
    localparam t_pc PC_MULY   = 5'd10;
    localparam t_pc PC_MULZ   = 5'd11;
    localparam t_pc PC_NUMZ   = 5'd12;
    localparam t_pc PC_DVLOAD = 5'd13;
    localparam t_pc PC_DVIT   = 5'd14;
    localparam t_pc PC_FIN    = 5'd15;
    localparam t_pc PC_EMIT   = 5'd16;

    localparam t_cnt SQRT_ITERS_M1 = 5'd16;
    localparam t_cnt DIV_ITERS_M1  = 5'd12;

    typedef enum logic [4:0] {
        A_NONE,
        A_READ,
        A_DIFF,
        A_SQX,
        A_SQY,
        A_SQZ,
        A_SQLOAD,
        A_SQIT,
        A_CMP,
        A_MULX,
        A_MULY,
        A_MULZ,
        A_NUMZ,
        A_DVLOAD,
        A_DVIT,
        A_FIN,
        A_EMIT
    } t_act;

    typedef enum logic [2:0] {
        C_NEXT,       // fall through
        C_WAIT_IN,    // hold at target until a beat is taken
        C_SKIP_IDLE,  // jump when the item needs no path work
        C_SKIP_NEAR,  // jump when no scaled step is needed
        C_LOOP,       // jump while the loop counter is nonzero
        C_WAIT_OUT    // jump once the output register is free, else hold
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
        logic  ld_cnt;
        t_cnt  cnt;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_WAIT:   w = '{A_NONE,   C_WAIT_IN,   PC_WAIT,   1'b0, 5'd0};
            PC_CHECK:  w = '{A_READ,   C_SKIP_IDLE, PC_EMIT,   1'b0, 5'd0};
            PC_DIFF:   w = '{A_DIFF,   C_NEXT,      PC_WAIT,   1'b0, 5'd0};
            PC_SQX:    w = '{A_SQX,    C_NEXT,      PC_WAIT,   1'b0, 5'd0};
            PC_SQY:    w = '{A_SQY,    C_NEXT,      PC_WAIT,   1'b0, 5'd0};
            PC_SQZ:    w = '{A_SQZ,    C_NEXT,      PC_WAIT,   1'b0, 5'd0};
            PC_SQLOAD: w = '{A_SQLOAD, C_NEXT,      PC_WAIT,   1'b1, SQRT_ITERS_M1};
            PC_SQIT:   w = '{A_SQIT,   C_LOOP,      PC_SQIT,   1'b0, 5'd0};
            PC_CMP:    w = '{A_CMP,    C_SKIP_NEAR, PC_EMIT,   1'b0, 5'd0};
            PC_MULX:   w = '{A_MULX,   C_NEXT,      PC_WAIT,   1'b0, 5'd0};
            PC_MULY:   w = '{A_MULY,   C_NEXT,      PC_WAIT,   1'b0, 5'd0};
            PC_MULZ:   w = '{A_MULZ,   C_NEXT,      PC_WAIT,   1'b0, 5'd0};
            PC_NUMZ:   w = '{A_NUMZ,   C_NEXT,      PC_WAIT,   1'b0, 5'd0};
            PC_DVLOAD: w = '{A_DVLOAD, C_NEXT,      PC_WAIT,   1'b1, DIV_ITERS_M1};
            PC_DVIT:   w = '{A_DVIT,   C_LOOP,      PC_DVIT,   1'b0, 5'd0};
            PC_FIN:    w = '{A_FIN,    C_NEXT,      PC_WAIT,   1'b0, 5'd0};
            PC_EMIT:   w = '{A_EMIT,   C_WAIT_OUT,  PC_WAIT,   1'b0, 5'd0};
            default:   w = '{A_NONE,   C_WAIT_IN,   PC_WAIT,   1'b0, 5'd0};
        endcase
        return w;
    endfunction

endpackage

>>> design/wfsc_divlane.sv
// One restoring divider lane: rounds a scaled axis offset over the step length.
`timescale 1ns / 1ps

module wfsc_divlane (
    input  logic                      i_clk,
    input  wfsc_pkg::t_div_ctl        i_ctl,
    input  logic [wfsc_pkg::NUM_W-1:0] i_num,
    input  logic [wfsc_pkg::DEN_W-1:0] i_den,
    output logic [wfsc_pkg::QUO_W-1:0] o_quo
);

    logic [wfsc_pkg::DEN_W-1:0] r_rem;
    logic [wfsc_pkg::QUO_W-1:0] r_lo;
    logic [wfsc_pkg::QUO_W-1:0] r_quo;
    logic [wfsc_pkg::DEN_W:0]   w_trial;
    logic [wfsc_pkg::DEN_W:0]   w_diff;
    logic                       w_ge;

    assign w_trial = {r_rem, r_lo[wfsc_pkg::QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign w_diff  = w_trial - {1'b0, i_den};

    // Quotient is known to fit QUO_W bits, so the high numerator bits start below i_den
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= wfsc_pkg::DEN_W'(i_num[wfsc_pkg::NUM_W-1:wfsc_pkg::QUO_W]);
            r_lo  <= i_num[wfsc_pkg::QUO_W-1:0];
            r_quo <= '0;
        end else if (i_ctl.step) begin
            r_rem <= w_ge ? wfsc_pkg::DEN_W'(w_diff) : wfsc_pkg::DEN_W'(w_trial);
            r_lo  <= {r_lo[wfsc_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[wfsc_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_quo = r_quo;

endmodule

>>> design/waypoint_follower_speed_clamp.sv
// Top level of the waypoint follower with per-tick step limit.
`timescale 1ns / 1ps

// Waypoint follower with step clamp. Each slave beat carries a code in tuser
// (tick, append, stop) and an x/y/z position in millimetres. Append stores a
// waypoint (up to MAX_WAYPOINTS) and starts following; stop clears the list.
// A tick measures the integer distance to the current waypoint: below
// arrival_radius the waypoint counts as reached and the index advances,
// otherwise a setpoint is issued, either the waypoint itself or the position
// moved max_step along the path, each axis rounded half away from zero.
// Every slave beat yields exactly one master beat. One item is in work at a
// time, run by a microcoded sequencer: append, stop and idle ticks go straight
// to the output step, a tick that reaches or lands on the waypoint ends after
// the distance compare, and a clamped step also runs the 13-iteration divide
// loop (three axis lanes side by side); every tick with path work runs the
// 17-iteration square-root loop. A finished result waits in the output register;
// the next beat is taken as soon as the sequencer is back at its wait step.
module waypoint_follower_speed_clamp #(
    parameter int MAX_WAYPOINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
    input  logic [1:0]  i_s_tuser,   // op[1:0]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // cmd_x[15:0], cmd_y[31:16], cmd_z[47:32],
                                     // target_index[52:48], zero[55:53]
    output logic [2:0]  o_m_tuser,   // status[2:0]
    // configuration
    input  logic                           i_cfg_we,
    input  logic [wfsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wfsc_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int PW = wfsc_pkg::POS_W;

    // ---------------------------------------------------------------- state
    logic [3*PW-1:0] r_mem [MAX_WAYPOINTS];

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_ptr;
    logic            r_following;
    logic [wfsc_pkg::CFG_W-1:0] r_max_step;
    logic [wfsc_pkg::CFG_W-1:0] r_arrival;

    wfsc_pkg::t_pc   r_pc,  n_pc;
    wfsc_pkg::t_cnt  r_cnt, n_cnt;
    wfsc_pkg::t_uword w_uw;

    // item payload
    logic            r_work;
    wfsc_pkg::t_status r_status;
    logic [PW-1:0]   r_pos [3];
    logic [3*PW-1:0] r_wp;
    logic [PW-1:0]   w_wp  [3];
    logic [wfsc_pkg::MAG_W-1:0] r_mag [3];
    logic            r_neg [3];
    logic [PW-1:0]   r_cmd [3];

    // arithmetic
    logic [wfsc_pkg::PRD_W-1:0] r_prod;
    logic [wfsc_pkg::SQ_W-1:0]  r_acc;
    logic [wfsc_pkg::SQ_W-1:0]  r_sq_n, r_sq_res, r_sq_bit;
    logic [wfsc_pkg::NUM_W-1:0] r_num [3];

    // output register
    logic            r_out_valid;
    wfsc_pkg::t_status r_out_status;
    logic [PW-1:0]   r_out_cmd [3];
    logic [wfsc_pkg::IDX_W-1:0] r_out_idx;

    // ----------------------------------------------------------- handshakes
    logic w_in_acc;
    logic w_out_free;
    logic w_full;
    wfsc_pkg::t_op w_op;

    assign o_s_tready = (r_pc == wfsc_pkg::PC_WAIT);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_full     = (r_count == CW'(MAX_WAYPOINTS));
    assign w_op       = i_s_tuser;

    assign w_uw = wfsc_pkg::ucode(r_pc);

    // -------------------------------------------------------- combinational
    logic [wfsc_pkg::LEN_W-1:0] w_len;
    logic                       w_reach;
    logic                       w_near;
    logic [PW:0]                w_d [3];
    logic [wfsc_pkg::MAG_W-1:0] w_mul_a, w_mul_b;
    logic [wfsc_pkg::SQ_W:0]    w_sq_try;
    logic                       w_sq_ge;
    logic [wfsc_pkg::NUM_W-1:0] w_num_new;
    logic [wfsc_pkg::DEN_W-1:0] w_den;
    logic [wfsc_pkg::QUO_W-1:0] w_quo [3];
    logic signed [PW:0]         w_off [3];
    logic [PW-1:0]              w_step_cmd [3];
    wfsc_pkg::t_div_ctl         w_div_ctl;
    logic [31:0]                w_ptr_ext;

    assign w_wp[0] = r_wp[PW-1:0];
    assign w_wp[1] = r_wp[2*PW-1:PW];
    assign w_wp[2] = r_wp[3*PW-1:2*PW];

    assign w_len   = r_sq_res[wfsc_pkg::LEN_W-1:0];
    assign w_reach = ({5'd0, r_arrival} > w_len);
    assign w_near  = w_reach || ({5'd0, r_max_step} >= w_len);
    assign w_den   = {w_len, 1'b0};

    assign w_sq_try = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign w_sq_ge  = ({1'b0, r_sq_n} >= w_sq_try);

    // numerator 2*|d|*max_step + len; the multiply sits in r_prod a step earlier
    assign w_num_new = wfsc_pkg::NUM_W'({r_prod, 1'b0} + 33'(w_len));

    assign w_div_ctl.load = (w_uw.act == wfsc_pkg::A_DVLOAD);
    assign w_div_ctl.step = (w_uw.act == wfsc_pkg::A_DVIT);

    assign w_ptr_ext = 32'(r_ptr);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i]   = {w_wp[i][PW-1], w_wp[i]} - {r_pos[i][PW-1], r_pos[i]};
            w_off[i] = $signed({4'd0, w_quo[i]});
            if (r_neg[i]) begin
                w_off[i] = -w_off[i];
            end
            w_step_cmd[i] = PW'($signed({r_pos[i][PW-1], r_pos[i]}) + w_off[i]);
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (w_uw.act)
            wfsc_pkg::A_SQX:  begin w_mul_a = r_mag[0]; w_mul_b = r_mag[0]; end
            wfsc_pkg::A_SQY:  begin w_mul_a = r_mag[1]; w_mul_b = r_mag[1]; end
            wfsc_pkg::A_SQZ:  begin w_mul_a = r_mag[2]; w_mul_b = r_mag[2]; end
            wfsc_pkg::A_MULX: begin w_mul_a = r_mag[0]; w_mul_b = 16'(r_max_step); end
            wfsc_pkg::A_MULY: begin w_mul_a = r_mag[1]; w_mul_b = 16'(r_max_step); end
            wfsc_pkg::A_MULZ: begin w_mul_a = r_mag[2]; w_mul_b = 16'(r_max_step); end
            default:          begin w_mul_a = r_mag[0]; w_mul_b = r_mag[0]; end
        endcase
    end

    // next step and loop counter
    always_comb begin
        unique case (w_uw.cond)
            wfsc_pkg::C_NEXT:      n_pc = r_pc + 5'd1;
            wfsc_pkg::C_WAIT_IN:   n_pc = w_in_acc ? r_pc + 5'd1 : w_uw.target;
            wfsc_pkg::C_SKIP_IDLE: n_pc = r_work ? r_pc + 5'd1 : w_uw.target;
            wfsc_pkg::C_SKIP_NEAR: n_pc = w_near ? w_uw.target : r_pc + 5'd1;
            wfsc_pkg::C_LOOP:      n_pc = (r_cnt != '0) ? w_uw.target : r_pc + 5'd1;
            wfsc_pkg::C_WAIT_OUT:  n_pc = w_out_free ? w_uw.target : r_pc;
            default:               n_pc = wfsc_pkg::PC_WAIT;
        endcase
        priority if (w_uw.ld_cnt) begin
            n_cnt = w_uw.cnt;
        end else if (w_uw.cond == wfsc_pkg::C_LOOP && r_cnt != '0) begin
            n_cnt = r_cnt - 5'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // ------------------------------------------------------------ divider
    for (genvar g = 0; g < 3; g++) begin : g_lane
        wfsc_divlane u_lane (
            .i_clk (i_clk),
            .i_ctl (w_div_ctl),
            .i_num (r_num[g]),
            .i_den (w_den),
            .o_quo (w_quo[g])
        );
    end

    // ------------------------------------------------------- control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= wfsc_pkg::PC_WAIT;
            r_cnt       <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_following <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_step  <= wfsc_pkg::MAX_STEP_RST;
            r_arrival   <= wfsc_pkg::ARRIVAL_RST;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;

            if (i_cfg_we) begin
                if (i_cfg_idx == wfsc_pkg::CFG_MAX_STEP) begin
                    r_max_step <= i_cfg_wdata;
                end
                if (i_cfg_idx == wfsc_pkg::CFG_ARRIVAL) begin
                    r_arrival <= i_cfg_wdata;
                end
            end

            // list bookkeeping happens on the accepted beat
            if (w_in_acc) begin
                if (w_op == wfsc_pkg::OP_APPEND && !w_full) begin
                    r_count     <= r_count + CW'(1);
                    r_following <= 1'b1;
                end else if (w_op == wfsc_pkg::OP_STOP) begin
                    r_count     <= '0;
                    r_ptr       <= '0;
                    r_following <= 1'b0;
                end
            end

            // advance past a reached waypoint
            if (w_uw.act == wfsc_pkg::A_CMP && w_reach) begin
                r_ptr <= r_ptr + CW'(1);
            end

            if (w_uw.act == wfsc_pkg::A_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ----------------------------------------------------- waypoint memory
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_op == wfsc_pkg::OP_APPEND && !w_full) begin
            r_mem[r_count[AW-1:0]] <= i_s_tdata;
        end
        if (w_uw.act == wfsc_pkg::A_READ && r_work) begin
            r_wp <= r_mem[r_ptr[AW-1:0]];
        end
    end

    // ------------------------------------------------------------ datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pos[0] <= i_s_tdata[PW-1:0];
            r_pos[1] <= i_s_tdata[2*PW-1:PW];
            r_pos[2] <= i_s_tdata[3*PW-1:2*PW];
            r_work   <= (w_op == wfsc_pkg::OP_TICK) && r_following && (r_ptr < r_count);
            for (int i = 0; i < 3; i++) begin
                r_cmd[i] <= '0;
            end
            if (w_op == wfsc_pkg::OP_APPEND && w_full) begin
                r_status <= wfsc_pkg::ST_FULL;
            end else if (w_op == wfsc_pkg::OP_TICK) begin
                r_status <= wfsc_pkg::ST_IDLE;
            end else begin
                r_status <= wfsc_pkg::ST_NONE;
            end
        end

        unique case (w_uw.act)
            wfsc_pkg::A_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= w_d[i][PW];
                    r_mag[i] <= w_d[i][PW] ? wfsc_pkg::MAG_W'(-w_d[i])
                                           : wfsc_pkg::MAG_W'(w_d[i]);
                end
            end
            wfsc_pkg::A_SQX: begin
                r_prod <= w_mul_a * w_mul_b;
                r_acc  <= '0;
            end
            wfsc_pkg::A_SQY, wfsc_pkg::A_SQZ: begin
                r_prod <= w_mul_a * w_mul_b;
                r_acc  <= r_acc + wfsc_pkg::SQ_W'(r_prod);
            end
            wfsc_pkg::A_SQLOAD: begin
                r_sq_n   <= r_acc + wfsc_pkg::SQ_W'(r_prod);
                r_sq_res <= '0;
                r_sq_bit <= wfsc_pkg::SQ_BIT0;
            end
            wfsc_pkg::A_SQIT: begin
                // one result bit per step: trial subtract of res + bit
                if (w_sq_ge) begin
                    r_sq_n   <= r_sq_n - wfsc_pkg::SQ_W'(w_sq_try);
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            wfsc_pkg::A_CMP: begin
                if (w_reach) begin
                    r_status <= wfsc_pkg::ST_REACHED;
                end else begin
                    r_status <= wfsc_pkg::ST_SETPT;
                    for (int i = 0; i < 3; i++) begin
                        r_cmd[i] <= w_wp[i];
                    end
                end
            end
            wfsc_pkg::A_MULX: begin
                r_prod <= w_mul_a * w_mul_b;
            end
            wfsc_pkg::A_MULY: begin
                r_prod   <= w_mul_a * w_mul_b;
                r_num[0] <= w_num_new;
            end
            wfsc_pkg::A_MULZ: begin
                r_prod   <= w_mul_a * w_mul_b;
                r_num[1] <= w_num_new;
            end
            wfsc_pkg::A_NUMZ: begin
                r_num[2] <= w_num_new;
            end
            wfsc_pkg::A_FIN: begin
                for (int i = 0; i < 3; i++) begin
                    r_cmd[i] <= w_step_cmd[i];
                end
            end
            default: begin
            end
        endcase

        if (w_uw.act == wfsc_pkg::A_EMIT && w_out_free) begin
            r_out_status <= r_status;
            r_out_idx    <= w_ptr_ext[wfsc_pkg::IDX_W-1:0];
            for (int i = 0; i < 3; i++) begin
                r_out_cmd[i] <= r_cmd[i];
            end
        end
    end

    // -------------------------------------------------------------- outputs
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {3'd0, r_out_idx, r_out_cmd[2], r_out_cmd[1], r_out_cmd[0]};

`ifndef ASSERT_OFF
    a_ptr_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_count)
        else $error("target pointer ran past waypoint count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_WAYPOINTS))
        else $error("waypoint count exceeds capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_tready)
        else $error("sequencer took a beat while an item was in work");

    a_reached_moves_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uw.act == wfsc_pkg::A_EMIT && w_out_free && r_status == wfsc_pkg::ST_REACHED)
        |-> (r_ptr != '0))
        else $error("reached status without pointer advance");
`endif

endmodule
